### hdl/pbpi_pkg.sv
// Package for the perspective barycentric pixel interpolator.
// Holds the beat types, the sideband bundles of the divider chains and fixed constants.
// No dependencies.
package pbpi_pkg;

   // action codes
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_PIXEL = 1'b1;

   // corners in the stored triangle
   localparam logic [1:0] CORNER_COUNT = 2'd3;

   // weight divider: 24 quotient bits over a 36-bit area magnitude
   localparam int W_QW = 24;
   localparam int W_DW = 36;
   // depth divider: 32 quotient bits over a positive 57-bit inverse-depth sum
   localparam int Z_QW = 32;
   localparam int Z_DW = 57;

   localparam logic signed [23:0] W_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] W_MIN = 24'sh800000;
   localparam logic [31:0]        DEPTH_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic               action;
      logic [1:0]         vertex_index;
      logic signed [15:0] vert_x;
      logic signed [15:0] vert_y;
      logic [31:0]        vert_inv_depth;
      logic signed [31:0] vert_tex_u;
      logic signed [31:0] vert_tex_v;
      logic signed [35:0] tri_area;
      logic [9:0]         pixel_x;
      logic [9:0]         pixel_y;
      logic [31:0]        stored_depth;
   } req_type;

   typedef struct packed {
      logic               visible;
      logic [31:0]        depth;
      logic signed [31:0] out_u;
      logic signed [31:0] out_v;
      logic [9:0]         out_x;
      logic [9:0]         out_y;
   } rsp_type;

   // pixel data that rides along the pipeline
   typedef struct packed {
      logic [9:0]  x;
      logic [9:0]  y;
      logic [31:0] stored;
   } pside_type;

   // per-lane flags of a weight division
   typedef struct packed {
      logic ovf;
      logic neg;
      logic zero;
   } wside_type;

   // flags and texture sums that ride along the depth division
   typedef struct packed {
      logic               nonpos;
      logic               ovf;
      logic signed [31:0] tu;
      logic signed [31:0] tv;
      pside_type          pix;
   } zside_type;

endpackage

### hdl/perspective_barycentric_pixel_interp.sv
// Perspective-correct barycentric interpolator for one stored triangle.
// Pixel beats pass through 24 weight cells, 32 depth cells and 10 arithmetic stages;
// throughput is one pixel per clock while the skid entry is empty.
// Load beats write the corner registers at once and give no result; a load waits while
// any pixel is still in the arithmetic stages. A two-entry output register and skid keep
// input flowing while a result waits. Reset clears all valid state; corners are undefined.
module perspective_barycentric_pixel_interp
   import pbpi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int EA [3] = '{1, 2, 0};
   localparam int EB [3] = '{2, 0, 1};
   localparam int PSW = $bits(pside_type);
   localparam int WSW = $bits(wside_type);
   localparam int ZSW = $bits(zside_type);

   // triangle storage
   logic signed [15:0] cx_ff [3];
   logic signed [15:0] cy_ff [3];
   logic [31:0]        cz_ff [3];
   logic signed [31:0] cu_ff [3];
   logic signed [31:0] cv_ff [3];
   logic [35:0]        area_mag_ff;
   logic               area_neg_ff;
   logic               area_zero_ff;

   logic adv, busy, acc, pix_acc, load_acc;
   logic w_busy, z_busy;
   logic [2:0] w_lane_busy;

   // stage registers
   logic               v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff, v10_ff;
   logic signed [17:0] dpx_ff [3], dpy_ff [3], dpx_in [3], dpy_in [3];
   logic signed [16:0] dby_ff [3], dbx_ff [3], dby_in [3], dbx_in [3];
   pside_type          p1_ff, p2_ff, p3_ff, p4_ff, p5_ff, p6_ff, p7_ff;
   logic signed [34:0] pa_ff [3], pb_ff [3];
   logic [35:0]        emag_ff [3];
   logic               eneg_ff [3];
   logic [35:0]        drem_ff [3];
   logic [23:0]        dnq_ff [3];
   wside_type          dside_ff [3];
   logic               wv [3];
   logic [23:0]        wq [3];
   wside_type          wsd [3];
   pside_type          wpix;
   logic signed [23:0] w_ff [3], w_in [3];
   logic signed [55:0] mz_ff [3], mu_ff [3], mv_ff [3];
   logic signed [57:0] s_ff, tu_ff, tv_ff;
   logic [56:0]        zrem_ff, zden_ff;
   zside_type          zside_ff, zside_in, zso, z9_ff;
   logic               zv;
   logic [31:0]        zq;
   logic [31:0]        depth9_ff, depth10_ff;
   logic signed [64:0] pu_ff, pv_ff;
   logic               vis10_ff, nonpos10_ff;
   pside_type          p10_ff;
   logic signed [17:0] pxs, pys;

   // output register and skid
   logic    rsp_valid_ff, skid_valid_ff;
   rsp_type rsp_ff, skid_ff, fin;

   function automatic logic signed [31:0] clamp32(input logic signed [48:0] val);
      logic signed [31:0] res;
      begin
         if (val > 49'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
         end else if (val < -49'sd2147483648) begin
            res = 32'sh8000_0000;
         end else begin
            res = val[31:0];
         end
         return res;
      end
   endfunction

   // handshake: the pipe moves while the skid is free, loads wait for the pipe to drain
   assign adv = ~skid_valid_ff;
   assign busy = v1_ff | v2_ff | v3_ff | v4_ff | w_busy | v5_ff | v6_ff | v7_ff
               | v8_ff | z_busy | v9_ff | v10_ff;
   assign req_stall = ~adv | (req_data.action == ACT_LOAD && busy);
   assign acc       = req_valid & ~req_stall;
   assign pix_acc   = acc & (req_data.action == ACT_PIXEL);
   assign load_acc  = acc & (req_data.action == ACT_LOAD)
                    & (req_data.vertex_index < CORNER_COUNT);

   // write one corner and the area on a load beat
   always_ff @(posedge clock) begin
      if (load_acc) begin
         cx_ff[req_data.vertex_index] <= req_data.vert_x;
         cy_ff[req_data.vertex_index] <= req_data.vert_y;
         cz_ff[req_data.vertex_index] <= req_data.vert_inv_depth;
         cu_ff[req_data.vertex_index] <= req_data.vert_tex_u;
         cv_ff[req_data.vertex_index] <= req_data.vert_tex_v;
         area_mag_ff  <= req_data.tri_area[35] ? 36'(-req_data.tri_area) : req_data.tri_area;
         area_neg_ff  <= req_data.tri_area[35];
         area_zero_ff <= (req_data.tri_area == '0);
      end
   end

   // edge-function differences at the integer pixel position in Q13.4
   always_comb begin
      pxs = $signed({4'b0000, req_data.pixel_x, 4'b0000});
      pys = $signed({4'b0000, req_data.pixel_y, 4'b0000});
      for (int i = 0; i < 3; i++) begin
         dpx_in[i] = pxs - 18'(cx_ff[EA[i]]);
         dpy_in[i] = pys - 18'(cy_ff[EA[i]]);
         dby_in[i] = 17'(cy_ff[EB[i]]) - 17'(cy_ff[EA[i]]);
         dbx_in[i] = 17'(cx_ff[EB[i]]) - 17'(cx_ff[EA[i]]);
      end
   end

   // valid bits of the arithmetic stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
      end else if (adv) begin
         v1_ff  <= pix_acc;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v4_ff  <= v3_ff;
         v5_ff  <= wv[0];
         v6_ff  <= v5_ff;
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
         v9_ff  <= zv;
         v10_ff <= v9_ff;
      end
   end

   // edge products, edge values, weight division setup
   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff <= '{x: req_data.pixel_x, y: req_data.pixel_y, stored: req_data.stored_depth};
         p2_ff <= p1_ff;
         p3_ff <= p2_ff;
         p4_ff <= p3_ff;
         for (int i = 0; i < 3; i++) begin
            dpx_ff[i] <= dpx_in[i];
            dpy_ff[i] <= dpy_in[i];
            dby_ff[i] <= dby_in[i];
            dbx_ff[i] <= dbx_in[i];
            pa_ff[i]  <= 35'(dpx_ff[i]) * 35'(dby_ff[i]);
            pb_ff[i]  <= 35'(dpy_ff[i]) * 35'(dbx_ff[i]);
            eneg_ff[i] <= (36'(pa_ff[i]) < 36'(pb_ff[i]));
            emag_ff[i] <= (36'(pa_ff[i]) < 36'(pb_ff[i])) ? 36'(pb_ff[i]) - 36'(pa_ff[i])
                                                          : 36'(pa_ff[i]) - 36'(pb_ff[i]);
            // quotient would reach 2^24 when the high numerator part meets the divisor
            dside_ff[i].ovf  <= ({8'b0, emag_ff[i][35:8]} >= area_mag_ff);
            dside_ff[i].neg  <= eneg_ff[i] ^ area_neg_ff;
            dside_ff[i].zero <= area_zero_ff;
            drem_ff[i] <= ({8'b0, emag_ff[i][35:8]} >= area_mag_ff) ? '0
                                                                 : {8'b0, emag_ff[i][35:8]};
            dnq_ff[i]  <= {emag_ff[i][7:0], 16'h0000};
         end
      end
   end

   // weight dividers, one lane per edge; lane 0 carries the pixel data
   logic [PSW+WSW-1:0] lane0_side;
   pbpi_divider #(.DW(W_DW), .QW(W_QW), .SW(PSW + WSW)) u_wdiv0 (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (v4_ff),
      .in_rem   (drem_ff[0]),
      .in_den   (area_mag_ff),
      .in_nq    (dnq_ff[0]),
      .in_side  ({p4_ff, dside_ff[0]}),
      .out_valid(wv[0]),
      .out_q    (wq[0]),
      .out_side (lane0_side),
      .busy     (w_lane_busy[0])
   );
   assign wpix   = pside_type'(lane0_side[PSW+WSW-1:WSW]);
   assign wsd[0] = wside_type'(lane0_side[WSW-1:0]);

   for (genvar l = 1; l < 3; l++) begin : g_wlane
      logic [WSW-1:0] side_out;
      pbpi_divider #(.DW(W_DW), .QW(W_QW), .SW(WSW)) u_wdiv (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .in_valid (v4_ff),
         .in_rem   (drem_ff[l]),
         .in_den   (area_mag_ff),
         .in_nq    (dnq_ff[l]),
         .in_side  (dside_ff[l]),
         .out_valid(wv[l]),
         .out_q    (wq[l]),
         .out_side (side_out),
         .busy     (w_lane_busy[l])
      );
      assign wsd[l] = wside_type'(side_out);
   end

   // any weight lane still holding a pixel
   assign w_busy = |w_lane_busy;

   // apply sign and saturate each weight to Q7.16
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (wsd[i].zero) begin
            w_in[i] = '0;
         end else if (wsd[i].ovf) begin
            w_in[i] = wsd[i].neg ? W_MIN : W_MAX;
         end else if (wsd[i].neg) begin
            w_in[i] = (wq[i][23] && wq[i][22:0] != '0) ? W_MIN : $signed(~wq[i] + 24'd1);
         end else begin
            w_in[i] = wq[i][23] ? W_MAX : $signed(wq[i]);
         end
      end
   end

   // weighted products, sums and depth division setup
   always_comb begin
      zside_in.nonpos = (s_ff <= 58'sd0);
      zside_in.ovf    = (s_ff <= 58'sd16777216);
      zside_in.tu     = clamp32(49'($signed(tu_ff[57:16])));
      zside_in.tv     = clamp32(49'($signed(tv_ff[57:16])));
      zside_in.pix    = p7_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p5_ff <= wpix;
         p6_ff <= p5_ff;
         p7_ff <= p6_ff;
         for (int i = 0; i < 3; i++) begin
            w_ff[i]  <= w_in[i];
            mz_ff[i] <= 56'(w_ff[i]) * $signed({24'h000000, cz_ff[i]});
            mu_ff[i] <= 56'(w_ff[i]) * 56'(cu_ff[i]);
            mv_ff[i] <= 56'(w_ff[i]) * 56'(cv_ff[i]);
         end
         s_ff  <= 58'(mz_ff[0]) + 58'(mz_ff[1]) + 58'(mz_ff[2]);
         tu_ff <= 58'(mu_ff[0]) + 58'(mu_ff[1]) + 58'(mu_ff[2]);
         tv_ff <= 58'(mv_ff[0]) + 58'(mv_ff[1]) + 58'(mv_ff[2]);
         // depth overflows 32 bits once the sum is at most 2^24
         zside_ff <= zside_in;
         zden_ff  <= s_ff[56:0];
         zrem_ff  <= zside_in.ovf ? '0 : 57'd16777216;
      end
   end

   // depth = 2^56 / sum, one bit per cell
   logic [ZSW-1:0] zside_out;
   pbpi_divider #(.DW(Z_DW), .QW(Z_QW), .SW(ZSW)) u_zdiv (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (v8_ff),
      .in_rem   (zrem_ff),
      .in_den   (zden_ff),
      .in_nq    ('0),
      .in_side  (zside_ff),
      .out_valid(zv),
      .out_q    (zq),
      .out_side (zside_out),
      .busy     (z_busy)
   );
   assign zso = zside_type'(zside_out);

   // saturate depth, then scale the texture sums by it
   always_ff @(posedge clock) begin
      if (adv) begin
         depth9_ff   <= zso.ovf ? DEPTH_MAX : zq;
         z9_ff       <= zso;
         pu_ff       <= 65'(z9_ff.tu) * $signed({33'h0, depth9_ff});
         pv_ff       <= 65'(z9_ff.tv) * $signed({33'h0, depth9_ff});
         depth10_ff  <= depth9_ff;
         vis10_ff    <= (depth9_ff <= z9_ff.pix.stored);
         nonpos10_ff <= z9_ff.nonpos;
         p10_ff      <= z9_ff.pix;
      end
   end

   always_comb begin
      fin.visible = vis10_ff;
      fin.depth   = depth10_ff;
      fin.out_u   = nonpos10_ff ? 32'sh0 : clamp32($signed(pu_ff[64:16]));
      fin.out_v   = nonpos10_ff ? 32'sh0 : clamp32($signed(pv_ff[64:16]));
      fin.out_x   = p10_ff.x;
      fin.out_y   = p10_ff.y;
   end

   // output register with one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (!rsp_stall) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= v10_ff;
      end else if (v10_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (!rsp_stall) begin
            rsp_ff <= skid_ff;
         end
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_ff <= fin;
      end else begin
         skid_ff <= fin;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // the three weight lanes move in lockstep
   assert property (@(posedge clock) disable iff (reset)
      (wv[0] == wv[1]) && (wv[1] == wv[2]))
      else $error("weight lanes out of step");

   // the skid only fills behind a held result
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a beat with empty output register");

   // a pixel with zero depth always passes the depth test
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.depth == 32'h0) |-> rsp_data.visible)
      else $error("zero depth reported hidden");

endmodule

### hdl/pbpi_div_cell.sv
// One restoring division step: shifts in one numerator bit, subtracts the
// divisor if it fits and shifts the quotient bit in. Registered outputs.
// No package dependencies.
module pbpi_div_cell #(
   parameter int DW = 36,
   parameter int QW = 24,
   parameter int SW = 3
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [DW-1:0] in_rem,
   input  logic [DW-1:0] in_den,
   input  logic [QW-1:0] in_nq,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [DW-1:0] out_rem,
   output logic [DW-1:0] out_den,
   output logic [QW-1:0] out_nq,
   output logic [SW-1:0] out_side
);

   logic          valid_ff;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff;
   logic [QW-1:0] nq_ff, nq_in;
   logic [SW-1:0] side_ff;
   logic [DW:0]   trial, diff;
   logic          take;

   // trial subtract of the divisor from the shifted remainder
   always_comb begin
      trial  = {in_rem, in_nq[QW-1]};
      diff   = trial - {1'b0, in_den};
      take   = ~diff[DW];
      rem_in = take ? diff[DW-1:0] : trial[DW-1:0];
      nq_in  = {in_nq[QW-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         den_ff  <= in_den;
         nq_ff   <= nq_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_nq    = nq_ff;
   assign out_side  = side_ff;

endmodule

### hdl/pbpi_divider.sv
// Chain of division cells, one quotient bit per cell.
// Depends on pbpi_div_cell. Caller guarantees the starting remainder is below the divisor.
module pbpi_divider #(
   parameter int DW = 36,
   parameter int QW = 24,
   parameter int SW = 3
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [DW-1:0] in_rem,
   input  logic [DW-1:0] in_den,
   input  logic [QW-1:0] in_nq,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_q,
   output logic [SW-1:0] out_side,
   output logic          busy
);

   logic [QW:0]   v;
   logic [DW-1:0] rem  [QW+1];
   logic [DW-1:0] den  [QW+1];
   logic [QW-1:0] nq   [QW+1];
   logic [SW-1:0] side [QW+1];

   assign v[0]    = in_valid;
   assign rem[0]  = in_rem;
   assign den[0]  = in_den;
   assign nq[0]   = in_nq;
   assign side[0] = in_side;

   // one cell per quotient bit, most significant first
   for (genvar k = 0; k < QW; k++) begin : g_cell
      pbpi_div_cell #(.DW(DW), .QW(QW), .SW(SW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (v[k]),
         .in_rem   (rem[k]),
         .in_den   (den[k]),
         .in_nq    (nq[k]),
         .in_side  (side[k]),
         .out_valid(v[k+1]),
         .out_rem  (rem[k+1]),
         .out_den  (den[k+1]),
         .out_nq   (nq[k+1]),
         .out_side (side[k+1])
      );
   end

   assign out_valid = v[QW];
   assign out_q     = nq[QW];
   assign out_side  = side[QW];
   assign busy      = |v[QW:1];

   // remainder stays below the divisor through the whole chain
   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (rem[QW] < den[QW] || den[QW] == '0))
      else $error("divider remainder escaped divisor");

endmodule
